// ===== sv/rsa_pkg.sv =====
// Package for the RSA modular exponentiation engine: widths, register
// indexes, reset values and the structs of the shared add / double unit.
// No dependencies.
`default_nettype none

package rsa_pkg;

   // Datapath widths
   localparam int MOD_BITS   = 32;
   localparam int PRIME_BITS = 16;
   localparam int CNT_BITS   = $clog2(MOD_BITS);
   localparam int IDX_BITS   = 3;

   // Configuration register indexes
   localparam logic [IDX_BITS-1:0] REG_MODULUS   = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_PUB_EXP   = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_PRIME_P   = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_PRIME_Q   = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_EXP_MOD_P = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_EXP_MOD_Q = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_Q_INVERSE = 3'd6;

   // Register reset values
   localparam logic [MOD_BITS-1:0]   RST_MODULUS = MOD_BITS'(2);
   localparam logic [MOD_BITS-1:0]   RST_PUB_EXP = MOD_BITS'(65537);
   localparam logic [PRIME_BITS-1:0] RST_PRIME   = PRIME_BITS'(2);

   // Input kinds
   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   // Operands of the shared modular add / double unit
   typedef struct packed {
      logic [MOD_BITS-1:0] modulus;
      logic [MOD_BITS-1:0] sum_a;
      logic [MOD_BITS-1:0] sum_b;
      logic                cin;
      logic [MOD_BITS-1:0] dbl_a;
   } mstep_req_type;

   typedef struct packed {
      logic [MOD_BITS-1:0] sum;
      logic [MOD_BITS-1:0] dbl;
   } mstep_rsp_type;

endpackage

`default_nettype wire

// ===== sv/rsa_req_if.sv =====
// Request channel of the RSA engine: valid/ready plus kind and value.
// Depends on rsa_pkg.
`default_nettype none

interface rsa_req_if;
   import rsa_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [MOD_BITS-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

// ===== sv/rsa_rsp_if.sv =====
// Response channel of the RSA engine: valid/ready plus the result word.
// Depends on rsa_pkg.
`default_nettype none

interface rsa_rsp_if;
   import rsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [MOD_BITS-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== sv/rsa_mstep.sv =====
// Shared modular add / double unit: (a + b + cin) mod m and (2d) mod m,
// each with a single conditional subtract. Depends on rsa_pkg.
`default_nettype none

module rsa_mstep (
   input  rsa_pkg::mstep_req_type op,
   output rsa_pkg::mstep_rsp_type res
);
   import rsa_pkg::*;

   logic [MOD_BITS:0] sum_raw;
   logic [MOD_BITS:0] dbl_raw;
   logic [MOD_BITS:0] mod_ext;
   logic [MOD_BITS:0] sum_red;
   logic [MOD_BITS:0] dbl_red;

   assign mod_ext = {1'b0, op.modulus};

   // operands are below m, so one subtract brings the sum back in range
   assign sum_raw = {1'b0, op.sum_a} + {1'b0, op.sum_b} + {{MOD_BITS{1'b0}}, op.cin};
   assign dbl_raw = {op.dbl_a, 1'b0};

   assign sum_red = (sum_raw >= mod_ext) ? (sum_raw - mod_ext) : sum_raw;
   assign dbl_red = (dbl_raw >= mod_ext) ? (dbl_raw - mod_ext) : dbl_raw;

   assign res.sum = sum_red[MOD_BITS-1:0];
   assign res.dbl = dbl_red[MOD_BITS-1:0];
endmodule

`default_nettype wire

// ===== sv/rsa_modexp_crt_engine.sv =====
// RSA word engine: square-and-multiply exponentiation with CRT decryption.
// Depends on rsa_pkg, rsa_req_if, rsa_rsp_if and rsa_mstep.
// Usage:
//  - req_if carries one transaction: kind (0 encrypt with modulus and
//    public exponent, 1 decrypt by CRT with p, q, dp, dq, qInv) and value.
//  - rsp_if returns one result word per request transaction.
//  - csr_we/csr_index/csr_wdata write the key registers; write them only
//    while the engine is idle.
//  - Flow: one reduction of the input, then per exponent bit a multiply for
//    a set bit and a squaring, the squaring skipped after the top bit. Each
//    modular multiply is a shift-and-add over the significant multiplier
//    bits, all on the single shared add/double unit. Decrypt runs a reduction
//    and a 16-bit exponentiation per prime, a qInv reduction and one multiply
//    (both skipped when the difference stays negative), and the difference
//    and recombination states S_DIFF, S_PROD and S_SUM.
//  - One transaction at a time: req_if.ready is high only while idle.
//  - The finished word goes to an output register and the engine takes the
//    next request; a second finished word waits until rsp_if.ready.
//  - Synchronous reset clears the sequencer and the output valid and loads
//    the register reset values.
`default_nettype none

module rsa_modexp_crt_engine (
   input  logic                            clock,
   input  logic                            reset,
   rsa_req_if.sink                         req_if,
   rsa_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [rsa_pkg::IDX_BITS-1:0]    csr_index,
   input  logic [rsa_pkg::MOD_BITS-1:0]    csr_wdata
);
   import rsa_pkg::*;

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RED  = 3'd1;
   localparam logic [2:0] S_EXP  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DIFF = 3'd4;
   localparam logic [2:0] S_PROD = 3'd5;
   localparam logic [2:0] S_SUM  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   // Exponentiation phase
   localparam logic [1:0] PH_ENC = 2'd0;
   localparam logic [1:0] PH_P   = 2'd1;
   localparam logic [1:0] PH_Q   = 2'd2;

   // Destination of a modular multiply
   localparam logic [1:0] DST_ACC  = 2'd0;
   localparam logic [1:0] DST_BASE = 2'd1;
   localparam logic [1:0] DST_H    = 2'd2;

   // Key registers
   logic [MOD_BITS-1:0]   modulus_ff;
   logic [MOD_BITS-1:0]   pub_exp_ff;
   logic [PRIME_BITS-1:0] prime_p_ff;
   logic [PRIME_BITS-1:0] prime_q_ff;
   logic [PRIME_BITS-1:0] exp_mod_p_ff;
   logic [PRIME_BITS-1:0] exp_mod_q_ff;
   logic [PRIME_BITS-1:0] q_inverse_ff;

   // Sequencer and datapath
   logic [2:0]            state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   logic [1:0]            dst_ff, dst_in;
   logic                  red_h_ff, red_h_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [MOD_BITS-1:0]   value_ff, value_in;
   logic [MOD_BITS-1:0]   mod_ff, mod_in;
   logic [MOD_BITS-1:0]   exp_ff, exp_in;
   logic [MOD_BITS-1:0]   base_ff, base_in;
   logic [MOD_BITS-1:0]   acc_ff, acc_in;
   logic [MOD_BITS-1:0]   ma_ff, ma_in;
   logic [MOD_BITS-1:0]   mb_ff, mb_in;
   logic [MOD_BITS-1:0]   mr_ff, mr_in;
   logic [PRIME_BITS-1:0] m1_ff, m1_in;
   logic [PRIME_BITS-1:0] m2_ff, m2_in;
   logic [PRIME_BITS-1:0] diff_ff, diff_in;
   logic [MOD_BITS-1:0]   out_result_ff, out_result_in;
   logic                  out_valid_ff, out_valid_in;

   logic                  req_accept;
   logic                  mod_is_one;
   logic [PRIME_BITS+1:0] diff_raw;
   logic [PRIME_BITS+1:0] diff_fix;
   mstep_req_type         unit_op;
   mstep_rsp_type         unit_res;

   // Key register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= RST_MODULUS;
         pub_exp_ff   <= RST_PUB_EXP;
         prime_p_ff   <= RST_PRIME;
         prime_q_ff   <= RST_PRIME;
         exp_mod_p_ff <= '0;
         exp_mod_q_ff <= '0;
         q_inverse_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MODULUS:   modulus_ff   <= csr_wdata;
            REG_PUB_EXP:   pub_exp_ff   <= csr_wdata;
            REG_PRIME_P:   prime_p_ff   <= csr_wdata[PRIME_BITS-1:0];
            REG_PRIME_Q:   prime_q_ff   <= csr_wdata[PRIME_BITS-1:0];
            REG_EXP_MOD_P: exp_mod_p_ff <= csr_wdata[PRIME_BITS-1:0];
            REG_EXP_MOD_Q: exp_mod_q_ff <= csr_wdata[PRIME_BITS-1:0];
            REG_Q_INVERSE: q_inverse_ff <= csr_wdata[PRIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Handshake
   assign req_if.ready  = (state_ff == S_IDLE) && !reset;
   assign req_accept    = req_if.valid && req_if.ready;
   assign rsp_if.valid  = out_valid_ff;
   assign rsp_if.result = out_result_ff;

   assign mod_is_one = (mod_ff == MOD_BITS'(1));

   // Shared unit: reduction step is 2r + bit, multiply step is acc + a and 2a
   always_comb begin
      unit_op.modulus = mod_ff;
      unit_op.sum_a   = mr_ff;
      unit_op.dbl_a   = ma_ff;
      if (state_ff == S_RED) begin
         unit_op.sum_b = mr_ff;
         unit_op.cin   = mb_ff[MOD_BITS-1];
      end else begin
         unit_op.sum_b = ma_ff;
         unit_op.cin   = 1'b0;
      end
   end

   rsa_mstep u_mstep (
      .op  (unit_op),
      .res (unit_res)
   );

   // CRT difference m1 - m2, corrected once by p
   assign diff_raw = {2'b00, m1_ff} - {2'b00, m2_ff};
   assign diff_fix = diff_raw[PRIME_BITS+1] ? (diff_raw + {2'b00, prime_p_ff}) : diff_raw;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      dst_in        = dst_ff;
      red_h_in      = red_h_ff;
      cnt_in        = cnt_ff;
      value_in      = value_ff;
      mod_in        = mod_ff;
      exp_in        = exp_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      mr_in         = mr_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      diff_in       = diff_ff;
      out_result_in = out_result_ff;
      out_valid_in  = out_valid_ff && !rsp_if.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               value_in = req_if.value;
               red_h_in = 1'b0;
               mr_in    = '0;
               mb_in    = req_if.value;
               cnt_in   = '0;
               if (req_if.kind == KIND_ENCRYPT) begin
                  phase_in = PH_ENC;
                  mod_in   = modulus_ff;
                  exp_in   = pub_exp_ff;
                  if (modulus_ff == '0) begin
                     acc_in   = '0;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_RED;
                  end
               end else begin
                  phase_in = PH_P;
                  mod_in   = MOD_BITS'(prime_p_ff);
                  exp_in   = MOD_BITS'(exp_mod_p_ff);
                  if (prime_p_ff == '0 || prime_q_ff == '0) begin
                     acc_in   = '0;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_RED;
                  end
               end
            end
         end

         // restoring remainder, one dividend bit per cycle
         S_RED: begin
            mr_in  = unit_res.sum;
            mb_in  = {mb_ff[MOD_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(MOD_BITS-1)) begin
               if (red_h_ff) begin
                  ma_in    = mod_is_one ? '0 : unit_res.sum;
                  mb_in    = MOD_BITS'(diff_ff);
                  mr_in    = '0;
                  dst_in   = DST_H;
                  state_in = S_MUL;
               end else begin
                  base_in  = unit_res.sum;
                  acc_in   = MOD_BITS'(1);
                  state_in = S_EXP;
               end
            end
         end

         // one exponent bit: multiply when set, then square; a zero exponent ends the phase
         S_EXP: begin
            if (exp_ff == '0) begin
               unique case (phase_ff)
                  PH_P: begin
                     m1_in    = acc_ff[PRIME_BITS-1:0];
                     phase_in = PH_Q;
                     mod_in   = MOD_BITS'(prime_q_ff);
                     exp_in   = MOD_BITS'(exp_mod_q_ff);
                     red_h_in = 1'b0;
                     mr_in    = '0;
                     mb_in    = value_ff;
                     cnt_in   = '0;
                     state_in = S_RED;
                  end
                  PH_Q: begin
                     m2_in    = acc_ff[PRIME_BITS-1:0];
                     state_in = S_DIFF;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end else begin
               mb_in    = base_ff;
               mr_in    = '0;
               state_in = S_MUL;
               if (exp_ff[0]) begin
                  ma_in  = mod_is_one ? '0 : acc_ff;
                  dst_in = DST_ACC;
               end else begin
                  ma_in  = mod_is_one ? '0 : base_ff;
                  dst_in = DST_BASE;
               end
            end
         end

         // shift-and-add multiply, ends when the multiplier runs out of bits
         S_MUL: begin
            if (mb_ff == '0) begin
               unique case (dst_ff)
                  DST_ACC: begin
                     acc_in = mr_ff;
                     if (exp_ff[MOD_BITS-1:1] == '0) begin
                        exp_in   = '0;
                        state_in = S_EXP;
                     end else begin
                        ma_in  = mod_is_one ? '0 : base_ff;
                        mb_in  = base_ff;
                        mr_in  = '0;
                        dst_in = DST_BASE;
                     end
                  end
                  DST_BASE: begin
                     base_in  = mr_ff;
                     exp_in   = {1'b0, exp_ff[MOD_BITS-1:1]};
                     state_in = S_EXP;
                  end
                  default: begin
                     acc_in   = mr_ff;
                     state_in = S_PROD;
                  end
               endcase
            end else begin
               if (mb_ff[0]) begin
                  mr_in = unit_res.sum;
               end
               ma_in = unit_res.dbl;
               mb_in = {1'b0, mb_ff[MOD_BITS-1:1]};
            end
         end

         // h = qInv * diff mod p, skipped when the difference stays negative
         S_DIFF: begin
            if (diff_fix[PRIME_BITS+1]) begin
               acc_in   = '0;
               state_in = S_PROD;
            end else begin
               diff_in  = diff_fix[PRIME_BITS-1:0];
               mod_in   = MOD_BITS'(prime_p_ff);
               red_h_in = 1'b1;
               mr_in    = '0;
               mb_in    = MOD_BITS'(q_inverse_ff);
               cnt_in   = '0;
               state_in = S_RED;
            end
         end

         S_PROD: begin
            acc_in   = MOD_BITS'(acc_ff[PRIME_BITS-1:0]) * MOD_BITS'(prime_q_ff);
            state_in = S_SUM;
         end

         S_SUM: begin
            acc_in   = acc_ff + MOD_BITS'(m2_ff);
            state_in = S_DONE;
         end

         // hand the word to the output register once it is free
         S_DONE: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_result_in = acc_ff;
               out_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      dst_ff        <= dst_in;
      red_h_ff      <= red_h_in;
      cnt_ff        <= cnt_in;
      value_ff      <= value_in;
      mod_ff        <= mod_in;
      exp_ff        <= exp_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      ma_ff         <= ma_in;
      mb_ff         <= mb_in;
      mr_ff         <= mr_in;
      m1_ff         <= m1_in;
      m2_ff         <= m2_in;
      diff_ff       <= diff_in;
      out_result_ff <= out_result_in;
   end
endmodule

`default_nettype wire

// ===== sv/rsa_chk.sv =====
// Port-level checks for the RSA engine, bound to the top level.
// Depends on rsa_pkg and rsa_modexp_crt_engine.
`default_nettype none

module rsa_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rsa_pkg::MOD_BITS-1:0] rsp_result
);
   import rsa_pkg::*;

   // one transaction at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // no result can be produced in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared without computation");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds its word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result)))
      else $error("stalled response changed");
endmodule

bind rsa_modexp_crt_engine rsa_chk u_rsa_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_result (rsp_if.result)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for rsa_modexp_crt_engine: random and directed words
// for both kinds, checked against a predictor of the key arithmetic.
// Depends on rsa_pkg, rsa_req_if, rsa_rsp_if and the engine RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rsa_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int HOLD_CYCLES = 5000;
   localparam int DRAIN_CYCLES = 2500;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic                kind;
      logic [MOD_BITS-1:0] value;
   } rsa_item_type;

   typedef struct {
      logic [MOD_BITS-1:0]   modulus;
      logic [MOD_BITS-1:0]   pub_exp;
      logic [PRIME_BITS-1:0] p;
      logic [PRIME_BITS-1:0] q;
      logic [PRIME_BITS-1:0] dp;
      logic [PRIME_BITS-1:0] dq;
      logic [PRIME_BITS-1:0] qinv;
   } rsa_keys_type;

   typedef struct {
      rsa_item_type        item;
      logic [MOD_BITS-1:0] result;
   } rsa_expect_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [IDX_BITS-1:0] csr_index;
   logic [MOD_BITS-1:0] csr_wdata;

   rsa_req_if req_bus ();
   rsa_rsp_if rsp_bus ();

   rsa_modexp_crt_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rsa_keys_type   keys;             // shadow of the key registers
   rsa_item_type   pending_items[$];
   rsa_expect_type expected_words[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          hold_left = 0;
   logic        hold_arm;
   bit          idle_on;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // (a * b) mod m; operands stay below 2^32 so the product fits in 64 bits
   function automatic bit [63:0] mod_product(bit [63:0] a, bit [63:0] b, bit [63:0] m);
      return ((a % m) * b) % m;
   endfunction

   // right-to-left square-and-multiply over 32 exponent bits
   function automatic bit [63:0] mod_power(bit [63:0] base, bit [31:0] ex, bit [63:0] m);
      bit [63:0] acc;
      int i;
      acc = 64'd1;
      base = base % m;
      for (i = 0; i < 32; i++) begin
         if (ex[i])
            acc = mod_product(acc, base, m);
         base = mod_product(base, base, m);
      end
      return acc;
   endfunction

   function automatic logic [MOD_BITS-1:0] rsa_transform(rsa_item_type it, rsa_keys_type k);
      bit [63:0] p, q, m1, m2, h;
      longint diff;
      if (it.kind == KIND_ENCRYPT) begin
         if (k.modulus == 0)
            return '0;
         return MOD_BITS'(mod_power(64'(it.value), k.pub_exp, 64'(k.modulus)));
      end
      p = 64'(k.p);
      q = 64'(k.q);
      if (p == 0 || q == 0)
         return '0;
      m1 = mod_power(64'(it.value) % p, 32'(k.dp), p);
      m2 = mod_power(64'(it.value) % q, 32'(k.dq), q);
      diff = longint'(m1) - longint'(m2);
      if (diff < 0)
         diff += longint'(p);
      // still negative only when q > p: no correction term
      h = 64'd0;
      if (diff >= 0)
         h = mod_product(64'(k.qinv), 64'(diff), p);
      return MOD_BITS'(m2 + h * q);
   endfunction

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------

   // mostly short gaps, a few long ones; none while idling is off
   function automatic int pick_gap();
      int roll;
      if (!idle_on)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 4);
      return $urandom_range(20, 400);
   endfunction

   task automatic flag_error(string msg);
      if (error_count < REPORT_MAX)
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [MOD_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_MODULUS:   keys.modulus = data;
         REG_PUB_EXP:   keys.pub_exp = data;
         REG_PRIME_P:   keys.p       = data[PRIME_BITS-1:0];
         REG_PRIME_Q:   keys.q       = data[PRIME_BITS-1:0];
         REG_EXP_MOD_P: keys.dp      = data[PRIME_BITS-1:0];
         REG_EXP_MOD_Q: keys.dq      = data[PRIME_BITS-1:0];
         REG_Q_INVERSE: keys.qinv    = data[PRIME_BITS-1:0];
         default: ;
      endcase
   endtask

   // write the full key set; only called while the engine is idle
   task automatic load_keys(rsa_keys_type k);
      write_reg(REG_MODULUS,   k.modulus);
      write_reg(REG_PUB_EXP,   k.pub_exp);
      write_reg(REG_PRIME_P,   MOD_BITS'(k.p));
      write_reg(REG_PRIME_Q,   MOD_BITS'(k.q));
      write_reg(REG_EXP_MOD_P, MOD_BITS'(k.dp));
      write_reg(REG_EXP_MOD_Q, MOD_BITS'(k.dq));
      write_reg(REG_Q_INVERSE, MOD_BITS'(k.qinv));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send(logic kind, logic [MOD_BITS-1:0] value);
      rsa_item_type it;
      it.kind  = kind;
      it.value = value;
      pending_items.push_back(it);
   endtask

   // wait until every transaction is in and every result is back
   task automatic drain();
      while (pending_items.size() != 0 || expected_words.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Clock and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: predicts each accepted transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsa_expect_type entry;
      logic taken;
      taken = req_bus.valid && req_bus.ready;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (taken) begin
            entry.item.kind  = req_bus.kind;
            entry.item.value = req_bus.value;
            entry.result     = rsa_transform(entry.item, keys);
            expected_words.push_back(entry);
            void'(pending_items.pop_front());
            req_gap = pick_gap();
         end
         // an offered transaction holds until accepted
         if (taken || !req_bus.valid) begin
            if (req_gap != 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.kind  <= pending_items[0].kind;
               req_bus.value <= pending_items[0].value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Long receiver hold-off, counted here
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_arm)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // ---------------------------------------------------------------------
   // Response monitor and checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsa_expect_type entry;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               flag_error($sformatf("unexpected result %h", rsp_bus.result));
            end else begin
               entry = expected_words.pop_front();
               if (rsp_bus.result !== entry.result)
                  flag_error($sformatf("kind %0d value %h: result %h, predicted %h",
                     entry.item.kind, entry.item.value, rsp_bus.result, entry.result));
            end
            rsp_gap = pick_gap();
         end else if (rsp_gap != 0) begin
            rsp_gap--;
         end
         rsp_bus.ready <= (rsp_gap == 0) && (hold_left == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      rsa_keys_type k;
      rsa_item_type probe;
      int ph, i;
      logic [MOD_BITS-1:0] m;

      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_ENCRYPT;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      csr_we        = 1'b0;
      csr_index     = REG_MODULUS;
      csr_wdata     = '0;
      hold_arm      = 1'b0;
      idle_on       = 1'b1;
      keys = '{modulus: RST_MODULUS, pub_exp: RST_PUB_EXP, p: RST_PRIME, q: RST_PRIME,
               dp: '0, dq: '0, qinv: '0};

      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset key values: modulus 2, zero private exponents
      send(KIND_ENCRYPT, 32'h0000_0000);
      send(KIND_ENCRYPT, 32'hFFFF_FFFF);
      send(KIND_DECRYPT, 32'h1234_5678);
      drain();

      // textbook key, with a long receiver hold-off so the engine backs up
      k = '{modulus: 32'd3233, pub_exp: 32'd17, p: 16'd61, q: 16'd53,
            dp: 16'd53, dq: 16'd49, qinv: 16'd38};
      load_keys(k);
      hold_arm <= 1'b1;
      @(posedge clock);
      hold_arm <= 1'b0;
      send(KIND_ENCRYPT, 32'd65);
      send(KIND_DECRYPT, 32'd2790);
      send(KIND_ENCRYPT, 32'd0);
      send(KIND_ENCRYPT, 32'd3232);
      send(KIND_DECRYPT, 32'hFFFF_FFFF);
      // round trips: encrypt a message, then decrypt its ciphertext
      for (i = 0; i < 12; i++) begin
         m = $urandom_range(0, 3232);
         probe.kind  = KIND_ENCRYPT;
         probe.value = m;
         send(KIND_ENCRYPT, m);
         send(KIND_DECRYPT, rsa_transform(probe, keys));
      end
      for (i = 0; i < 6; i++)
         send(($urandom_range(0, 1) != 0) ? KIND_DECRYPT : KIND_ENCRYPT, $urandom);
      drain();

      // largest keys and exponents: slowest path
      k = '{modulus: 32'hFFFF_FFFF, pub_exp: 32'hFFFF_FFFF, p: 16'hFFFF, q: 16'hFFFF,
            dp: 16'hFFFF, dq: 16'hFFFF, qinv: 16'hFFFF};
      load_keys(k);
      send(KIND_ENCRYPT, 32'h0000_0000);
      send(KIND_ENCRYPT, 32'hFFFF_FFFF);
      send(KIND_ENCRYPT, 32'hFFFF_FFFE);
      send(KIND_DECRYPT, 32'h0000_0000);
      send(KIND_DECRYPT, 32'hFFFF_FFFF);
      for (i = 0; i < 8; i++)
         send(($urandom_range(0, 1) != 0) ? KIND_DECRYPT : KIND_ENCRYPT, $urandom);
      drain();

      // modulus of one with zero exponent gives one
      k = '{modulus: 32'd1, pub_exp: 32'd0, p: 16'd61, q: 16'd53,
            dp: 16'd53, dq: 16'd49, qinv: 16'd38};
      load_keys(k);
      send(KIND_ENCRYPT, 32'hDEAD_BEEF);
      drain();
      // modulus of one with nonzero exponent gives zero
      k.pub_exp = 32'd5;
      load_keys(k);
      send(KIND_ENCRYPT, 32'd7);
      drain();
      // zero modulus, then zero primes
      k.modulus = 32'd0;
      k.p       = 16'd0;
      load_keys(k);
      send(KIND_ENCRYPT, 32'd123);
      send(KIND_DECRYPT, 32'd99);
      drain();
      k.p = 16'd61;
      k.q = 16'd0;
      load_keys(k);
      send(KIND_DECRYPT, 32'd4321);
      drain();
      // q much larger than p: difference stays negative after adding p
      k = '{modulus: 32'd3233, pub_exp: 32'd17, p: 16'd3, q: 16'd65521,
            dp: 16'd0, dq: 16'd5, qinv: 16'd7};
      load_keys(k);
      send(KIND_DECRYPT, 32'd12345);
      send(KIND_DECRYPT, 32'hFFFF_FFFF);
      drain();

      // random key sets; one phase runs without idling
      for (ph = 0; ph < 8; ph++) begin
         k.modulus = $urandom >> $urandom_range(0, 30);
         if (k.modulus < 2)
            k.modulus = 2;
         k.pub_exp = $urandom >> $urandom_range(0, 31);
         k.p    = PRIME_BITS'($urandom_range(2, 65535));
         k.q    = PRIME_BITS'($urandom_range(2, 65535));
         k.dp   = PRIME_BITS'($urandom_range(0, 65535));
         k.dq   = PRIME_BITS'($urandom_range(0, 65535));
         k.qinv = PRIME_BITS'($urandom_range(0, 65535));
         idle_on = (ph != 3);
         load_keys(k);
         for (i = 0; i < 28; i++)
            send(($urandom_range(0, 1) != 0) ? KIND_DECRYPT : KIND_ENCRYPT, $urandom);
         drain();
      end
      idle_on = 1'b1;

      // catch any late or extra result
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_words.size()));

      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rsa_pkg.sv
sv/rsa_req_if.sv
sv/rsa_rsp_if.sv
sv/rsa_mstep.sv
sv/rsa_modexp_crt_engine.sv
sv/rsa_chk.sv
tb/testbench.sv
